FILE: rtl/core/tsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsu_pkg
// Types, constants and multiplier helpers for the Taylor sine unit.
// ----------------------------------------------------------------------------
package tsu_pkg;

  localparam int unsigned MAX_TERMS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF = 30;
  localparam int unsigned MAG_W         = 57;
  localparam int unsigned RECIP_BITS    = 62;
  localparam int unsigned THR_W         = 10;
  localparam int unsigned SUM_W         = 64;

  localparam logic [MAG_W-1:0] MAG_CAP    = MAG_W'(64'd1 << 56);
  localparam logic [THR_W-1:0] THR_RESET  = 10'd11;
  localparam logic [1:0]       ADDR_THR   = 2'd0;

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  typedef struct packed {
    logic                    neg;
    logic                    act;
    logic [MAG_W-1:0]        term;
    logic [MAG_W-1:0]        x2;
    logic signed [SUM_W-1:0] sum;
    pp_t                     pp;
  } stage_t;

  // partial products of a 57-bit by 64-bit multiply, each at most 29 x 32
  function automatic pp_t mul_pp(input logic [MAG_W-1:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = 64'({35'd0, a[28:0]} * {32'd0, b[31:0]});
    p.lh = 64'({35'd0, a[28:0]} * {32'd0, b[63:32]});
    p.hl = 64'({36'd0, a[56:29]} * {32'd0, b[31:0]});
    p.hh = 64'({36'd0, a[56:29]} * {32'd0, b[63:32]});
    return p;
  endfunction

  // combine, round half up, shift and saturate at MAG_CAP
  function automatic logic [MAG_W-1:0] mul_fin(input pp_t p, input int unsigned sh);
    logic [127:0] full;
    logic [127:0] q;
    full = {64'd0, p.ll} + ({64'd0, p.lh} << 32) + ({64'd0, p.hl} << 29)
         + ({64'd0, p.hh} << 61);
    full = full + (128'd1 << (sh - 1));
    q = full >> sh;
    if (q > {71'd0, MAG_CAP}) begin
      return MAG_CAP;
    end
    return q[MAG_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/taylor_sine_unit_core.sv
// Throughput: one transaction per cycle; every series term owns four pipeline stages
// (two split multiplies, each partial products then combine and round).
// The whole pipeline holds while a result waits on out_tready.
// Reset (rst_n low, synchronous) drops all valid bits and sets stop_threshold to 11.
`default_nettype none
// ----------------------------------------------------------------------------
// taylor_sine_unit_core
// Sine of a fixed-point angle by a pipelined, early-stopping Taylor series.
// ----------------------------------------------------------------------------
module taylor_sine_unit_core
  import tsu_pkg::*;
#(
  parameter int unsigned MAX_TERMS = MAX_TERMS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] angle
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] sine
  output logic             out_tuser,  // [0] term_cap_hit
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned NT = MAX_TERMS - 1;
  localparam int unsigned NS = 4 * NT + 1;

  logic [THR_W-1:0] thr_r;
  logic             adv;
  logic             s0_vld_r, s1_vld_r;
  stage_t           s0_r, s1_r;
  stage_t           s0_nxt, s1_nxt, st0_nxt;
  logic [NS-1:0]    vld_r;
  stage_t           st_r [NS];
  logic             out_valid_r;
  logic [31:0]      out_data_r;
  logic             out_hit_r;
  stage_t           fin;
  logic             hit_nxt;
  logic [31:0]      sine_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-THR_W){1'b0}}, thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_THR) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r    <= in_tvalid;
      s1_vld_r    <= s0_vld_r;
      vld_r       <= {vld_r[NS-2:0], s1_vld_r};
      out_valid_r <= vld_r[NS-1];
    end
  end

  // front end: magnitude, square, first term
  always_comb begin
    s0_nxt      = '0;
    s0_nxt.neg  = in_tdata[31];
    s0_nxt.term = MAG_W'(in_tdata[31] ? 32'(-in_tdata) : in_tdata);
    s1_nxt      = s0_r;
    s1_nxt.pp   = mul_pp(s0_r.term, {7'd0, s0_r.term});
    st0_nxt     = s1_r;
    st0_nxt.act = 1'b1;
    st0_nxt.x2  = mul_fin(s1_r.pp, FRAC_BITS);
    st0_nxt.sum = s1_r.neg ? -$signed({7'd0, s1_r.term}) : $signed({7'd0, s1_r.term});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r    <= s0_nxt;
      s1_r    <= s1_nxt;
      st_r[0] <= st0_nxt;
    end
  end

  // one group of four stages per series term
  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam logic [63:0] DIV   = 64'((2 * (j + 1)) * (2 * (j + 1) + 1));
    localparam logic [63:0] RECIP = ((64'd1 << RECIP_BITS) + DIV / 2) / DIV;
    localparam bit          ODD   = ((j + 1) % 2) == 1;

    stage_t           t1_nxt, t2_nxt, t3_nxt, t4_nxt;
    logic [MAG_W-1:0] t4_term;

    always_comb begin
      t1_nxt     = st_r[4*j];
      t1_nxt.act = st_r[4*j].act && (st_r[4*j].term > MAG_W'(thr_r));
      t1_nxt.pp  = mul_pp(st_r[4*j].term, {7'd0, st_r[4*j].x2});

      t2_nxt      = st_r[4*j+1];
      t2_nxt.term = mul_fin(st_r[4*j+1].pp, FRAC_BITS);

      t3_nxt    = st_r[4*j+2];
      t3_nxt.pp = mul_pp(st_r[4*j+2].term, RECIP);

      t4_term     = mul_fin(st_r[4*j+3].pp, RECIP_BITS);
      t4_nxt      = st_r[4*j+3];
      t4_nxt.term = t4_term;
      if (st_r[4*j+3].act) begin
        if (st_r[4*j+3].neg ^ ODD) begin
          t4_nxt.sum = st_r[4*j+3].sum - $signed({7'd0, t4_term});
        end else begin
          t4_nxt.sum = st_r[4*j+3].sum + $signed({7'd0, t4_term});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[4*j+1] <= t1_nxt;
        st_r[4*j+2] <= t2_nxt;
        st_r[4*j+3] <= t3_nxt;
        st_r[4*j+4] <= t4_nxt;
      end
    end
  end

  // saturate and flag the term cap
  always_comb begin
    fin     = st_r[NS-1];
    hit_nxt = fin.act && (fin.term > MAG_W'(thr_r));
    if (fin.sum > 64'sd2147483647) begin
      sine_nxt = 32'h7FFF_FFFF;
    end else if (fin.sum < -64'sd2147483648) begin
      sine_nxt = 32'h8000_0000;
    end else begin
      sine_nxt = fin.sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= sine_nxt;
      out_hit_r  <= hit_nxt;
    end
  end

  a_init_active: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> st_r[0].act) else $error("first term stage not active");

  a_term_capped: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] |-> st_r[NS-1].term <= MAG_CAP) else $error("term above cap");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid) else $error("result valid after reset");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid) else $error("stall without pending result");

endmodule
`default_nettype wire
